### rtl/fcr_pkg.sv
// Shared types and constants for the fan tachometer count to rpm converter.
`timescale 1ns / 1ps
`default_nettype none

package fcr_pkg;

   // Conversion constant: rpm = RPM_NUMERATOR / (count << exponent)
   localparam int unsigned QUO_WIDTH = 21;
   localparam logic [QUO_WIDTH-1:0] RPM_NUMERATOR = 21'd1350000;

   // Divider pipeline shape: quotient bits resolved per stage
   localparam int unsigned STEP_BITS  = 3;
   localparam int unsigned NUM_STAGES = QUO_WIDTH / STEP_BITS;

   // Queue between classifier and divider (power of two)
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam int unsigned COUNT_WIDTH = 8;
   localparam int unsigned EXPO_WIDTH  = 3;
   localparam int unsigned STAT_WIDTH  = 2;

   localparam logic [COUNT_WIDTH-1:0] COUNT_STUCK_LOW  = 8'd0;
   localparam logic [COUNT_WIDTH-1:0] COUNT_STUCK_HIGH = 8'd255;

   // Fan channel codes
   localparam logic [1:0] CHAN_FAN_ONE   = 2'd0;
   localparam logic [1:0] CHAN_FAN_TWO   = 2'd1;
   localparam logic [1:0] CHAN_FAN_THREE = 2'd2;

   // Status codes
   localparam logic [STAT_WIDTH-1:0] STATUS_OK          = 2'd0;
   localparam logic [STAT_WIDTH-1:0] STATUS_STUCK       = 2'd1;
   localparam logic [STAT_WIDTH-1:0] STATUS_BAD_CHANNEL = 2'd2;

   typedef struct packed {
      logic [1:0]             func;
      logic [COUNT_WIDTH-1:0] fan_count;
      logic [7:0]             divisor_reg;
      logic [7:0]             pin_reg;
      logic [7:0]             battery_reg;
   } req_type;

   typedef struct packed {
      logic [QUO_WIDTH-1:0]  rpm;
      logic [STAT_WIDTH-1:0] status;
   } rsp_type;

   // Classified conversion job handed from front to back
   typedef struct packed {
      logic [COUNT_WIDTH-1:0] count;
      logic [EXPO_WIDTH-1:0]  expo;
      logic [STAT_WIDTH-1:0]  status;
   } job_type;

endpackage : fcr_pkg

`default_nettype wire

### rtl/fcr_front.sv
// Front end: picks the divisor exponent and checks channel and count.
`timescale 1ns / 1ps
`default_nettype none

module fcr_front (
   input  logic             has_third_bit,
   input  fcr_pkg::req_type req,
   output fcr_pkg::job_type job
);
   import fcr_pkg::*;

   logic [1:0] expo_low;
   logic       expo_high;

   always_comb begin
      unique case (req.func)
         CHAN_FAN_ONE: begin
            expo_low  = req.divisor_reg[5:4];
            expo_high = req.battery_reg[5];
         end
         CHAN_FAN_TWO: begin
            expo_low  = req.divisor_reg[7:6];
            expo_high = req.battery_reg[6];
         end
         CHAN_FAN_THREE: begin
            expo_low  = req.pin_reg[7:6];
            expo_high = req.battery_reg[7];
         end
         default: begin
            expo_low  = 2'd0;
            expo_high = 1'b0;
         end
      endcase
   end

   always_comb begin
      job.count = req.fan_count;
      job.expo  = {expo_high & has_third_bit, expo_low};
      priority if (req.func != CHAN_FAN_ONE && req.func != CHAN_FAN_TWO &&
                   req.func != CHAN_FAN_THREE) begin
         job.status = STATUS_BAD_CHANNEL;
      end else if (req.fan_count == COUNT_STUCK_LOW ||
                   req.fan_count == COUNT_STUCK_HIGH) begin
         job.status = STATUS_STUCK;
      end else begin
         job.status = STATUS_OK;
      end
   end

endmodule : fcr_front

`default_nettype wire

### rtl/fcr_queue.sv
// Short FIFO of classified jobs between front end and divider.
`timescale 1ns / 1ps
`default_nettype none

module fcr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  fcr_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output fcr_pkg::job_type head_job
);
   import fcr_pkg::*;

   localparam int unsigned PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_WIDTH-1:0] DEPTH_CNT = CNT_WIDTH'(QUEUE_DEPTH);

   job_type                entry_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;

   assign full       = (count_ff == DEPTH_CNT);
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CNT_WIDTH'(push) - CNT_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule : fcr_queue

`default_nettype wire

### rtl/fcr_back.sv
// Back end: pipelined restoring divider, exponent shift and output register.
`timescale 1ns / 1ps
`default_nettype none

module fcr_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  fcr_pkg::job_type job,
   output logic             job_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output fcr_pkg::rsp_type rsp_data
);
   import fcr_pkg::*;

   localparam int unsigned LAST = NUM_STAGES - 1;

   logic                   advance;
   logic                   vld_ff [NUM_STAGES];
   logic [COUNT_WIDTH-1:0] rem_ff [NUM_STAGES];
   logic [QUO_WIDTH-1:0]   quo_ff [NUM_STAGES];
   job_type                job_ff [NUM_STAGES];

   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   // The whole pipe moves together; hold it while a result waits
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign job_pop = advance && job_valid;

   for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
      logic                   vld_src;
      logic [COUNT_WIDTH-1:0] rem_src;
      logic [QUO_WIDTH-1:0]   quo_src;
      job_type                job_src;
      logic [COUNT_WIDTH-1:0] rem_in;
      logic [QUO_WIDTH-1:0]   quo_in;

      if (s == 0) begin : g_first
         assign vld_src = job_valid;
         assign rem_src = '0;
         assign quo_src = '0;
         assign job_src = job;
      end else begin : g_next
         assign vld_src = vld_ff[s-1];
         assign rem_src = rem_ff[s-1];
         assign quo_src = quo_ff[s-1];
         assign job_src = job_ff[s-1];
      end

      // Resolve STEP_BITS quotient bits: shift in a numerator bit, trial subtract
      always_comb begin
         logic [COUNT_WIDTH:0] trial;
         logic [COUNT_WIDTH:0] diff;
         rem_in = rem_src;
         quo_in = quo_src;
         for (int k = 0; k < STEP_BITS; k++) begin
            trial = {rem_in, RPM_NUMERATOR[QUO_WIDTH - 1 - STEP_BITS * s - k]};
            diff  = trial - {1'b0, job_src.count};
            if (trial >= {1'b0, job_src.count}) begin
               rem_in = diff[COUNT_WIDTH-1:0];
               quo_in = {quo_in[QUO_WIDTH-2:0], 1'b1};
            end else begin
               rem_in = trial[COUNT_WIDTH-1:0];
               quo_in = {quo_in[QUO_WIDTH-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (advance) begin
            vld_ff[s] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[s] <= rem_in;
            quo_ff[s] <= quo_in;
            job_ff[s] <= job_src;
         end
      end
   end

   // floor(floor(N / count) / 2^e) equals floor(N / (count << e))
   always_comb begin
      rsp_valid_in       = vld_ff[LAST];
      rsp_data_in.status = job_ff[LAST].status;
      if (job_ff[LAST].status == STATUS_OK) begin
         rsp_data_in.rpm = quo_ff[LAST] >> job_ff[LAST].expo;
      end else begin
         rsp_data_in.rpm = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule : fcr_back

`default_nettype wire

### rtl/fan_count_to_rpm_core.sv
// Top level: fan tachometer count to rpm converter.
//
//   port group   direction   flow control      contents
//   req_*        in          valid / stall     channel, count, register bytes
//   rsp_*        out         valid / stall     rpm and status
//   csr_*        in          write enable      third divisor bit enable
//
// One transaction is accepted per cycle while req_stall is low. Each result
// passes through the job queue, then 7 divider stages of 3 quotient bits each,
// then the output register that drives rsp_*. Synchronous active-high reset
// empties the queue and the pipe and clears the control register. A stalled
// output holds the whole divider pipe; the 2-entry queue absorbs requests
// until it fills, and only then is req_stall raised.
`timescale 1ns / 1ps
`default_nettype none

module fan_count_to_rpm_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  fcr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output fcr_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic             csr_wr_data
);
   import fcr_pkg::*;

   logic    has_third_bit_ff, has_third_bit_in;
   job_type front_job;
   job_type head_job;
   logic    q_push, q_full, q_pop, q_head_valid;

   assign has_third_bit_in = csr_wr_en ? csr_wr_data : has_third_bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         has_third_bit_ff <= 1'b0;
      end else begin
         has_third_bit_ff <= has_third_bit_in;
      end
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !req_stall;

   fcr_front u_front (
      .has_third_bit (has_third_bit_ff),
      .req           (req_data),
      .job           (front_job)
   );

   fcr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (front_job),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_job   (head_job)
   );

   fcr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (q_head_valid),
      .job       (head_job),
      .job_pop   (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Any error result carries zero rpm
   a_error_zero_rpm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_OK |-> rsp_data.rpm == '0)
      else $error("error result with nonzero rpm");

   // Smallest good rpm is 1350000 / (254 << 7), never zero
   a_ok_nonzero_rpm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_OK |-> rsp_data.rpm != '0)
      else $error("good result with zero rpm");

   // The queue fills only through an accepted request
   a_stall_after_push: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid))
      else $error("req_stall rose without a request");

endmodule : fan_count_to_rpm_core

`default_nettype wire

### test/tb_fan_count_to_rpm_core.sv
// Testbench for the fan tachometer count to rpm converter: directed table plus random traffic.
`timescale 1ns / 1ps

module tb_fan_count_to_rpm_core;
   import fcr_pkg::*;

   localparam logic [1:0] CHAN_INVALID = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam int unsigned ITEMS_PER_PHASE = 225;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type rsp;
   } fan_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_wr_en;
   logic    csr_wr_data;

   rsp_type     rpm_expected[$];
   fan_row_type fan_rows[$];
   logic        third_bit_on;
   bit          idle_on;
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;
   int unsigned stall_left = 0;

   fan_count_to_rpm_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Expected rpm and status for one request under the current control bit.
   function automatic rsp_type predict_rpm(input req_type r, input logic third_on);
      logic [2:0]  expo;
      logic        high_bit;
      int unsigned divisor;
      rsp_type     res;
      case (r.func)
         CHAN_FAN_ONE: begin
            expo     = {1'b0, r.divisor_reg[5:4]};
            high_bit = r.battery_reg[5];
         end
         CHAN_FAN_TWO: begin
            expo     = {1'b0, r.divisor_reg[7:6]};
            high_bit = r.battery_reg[6];
         end
         CHAN_FAN_THREE: begin
            expo     = {1'b0, r.pin_reg[7:6]};
            high_bit = r.battery_reg[7];
         end
         default: begin
            expo     = 3'd0;
            high_bit = 1'b0;
         end
      endcase
      res.rpm = '0;
      if (r.func == CHAN_INVALID) begin
         res.status = STATUS_BAD_CHANNEL;
      end else if (r.fan_count == COUNT_STUCK_LOW || r.fan_count == COUNT_STUCK_HIGH) begin
         res.status = STATUS_STUCK;
      end else begin
         if (third_on) expo[2] = high_bit;
         divisor    = int'(r.fan_count) << expo;
         res.rpm    = QUO_WIDTH'(int'(RPM_NUMERATOR) / divisor);
         res.status = STATUS_OK;
      end
      return res;
   endfunction

   task automatic add_row(input logic [1:0] func, input logic [7:0] count,
                          input logic [7:0] div, input logic [7:0] pin,
                          input logic [7:0] bat, input bit typed,
                          input logic [QUO_WIDTH-1:0] rpm, input logic [1:0] status);
      fan_row_type row;
      row.req.func        = func;
      row.req.fan_count   = count;
      row.req.divisor_reg = div;
      row.req.pin_reg     = pin;
      row.req.battery_reg = bat;
      row.typed           = typed;
      row.rsp.rpm         = rpm;
      row.rsp.status      = status;
      fan_rows.push_back(row);
   endtask

   // Drive one transaction and record what it must produce once accepted.
   task automatic send_fan_req(input req_type r, input bit typed, input rsp_type want);
      int unsigned gap;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap       = $urandom_range(1, 3);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = r;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      rpm_expected.push_back(typed ? want : predict_rpm(r, third_bit_on));
   endtask

   task automatic write_third_bit(input logic value);
      @(negedge clock);
      req_valid = 1'b0;
      while (rpm_expected.size() != 0) @(posedge clock);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en    = 1'b0;
      third_bit_on = value;
   endtask

   task automatic run_table;
      foreach (fan_rows[i]) send_fan_req(fan_rows[i].req, fan_rows[i].typed, fan_rows[i].rsp);
   endtask

   task automatic run_random(input int unsigned count, input int unsigned quiet_from,
                             input int unsigned quiet_to);
      req_type r;
      rsp_type dummy;
      dummy = '0;
      for (int unsigned i = 0; i < count; i++) begin
         idle_on = !(i >= quiet_from && i < quiet_to);
         r.func  = ($urandom_range(0, 9) == 0) ? CHAN_INVALID : 2'($urandom_range(0, 2));
         case ($urandom_range(0, 15))
            0:       r.fan_count = COUNT_STUCK_LOW;
            1:       r.fan_count = COUNT_STUCK_HIGH;
            2:       r.fan_count = 8'($urandom_range(1, 4));
            default: r.fan_count = 8'($urandom_range(1, 254));
         endcase
         r.divisor_reg = 8'($urandom);
         r.pin_reg     = 8'($urandom);
         r.battery_reg = 8'($urandom);
         send_fan_req(r, 1'b0, dummy);
      end
      idle_on = 1'b1;
   endtask

   // Result side: random stall bursts, started only while idle_on is set.
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_stall  = 1'b1;
         stall_left = stall_left - 1;
      end else if (idle_on && !reset && $urandom_range(0, 4) == 0) begin
         rsp_stall  = 1'b1;
         stall_left = $urandom_range(0, 2);
      end else begin
         rsp_stall = 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rpm_expected.size() == 0) begin
            $error("unexpected result: rpm %0d status %0d", rsp_data.rpm, rsp_data.status);
            mismatches++;
         end else begin
            if (rsp_data.rpm !== rpm_expected[0].rpm) begin
               $error("rpm: expected %0d, got %0d", rpm_expected[0].rpm, rsp_data.rpm);
               mismatches++;
            end
            if (rsp_data.status !== rpm_expected[0].status) begin
               $error("status: expected %0d, got %0d", rpm_expected[0].status,
                      rsp_data.status);
               mismatches++;
            end
            void'(rpm_expected.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_wr_en    = 1'b0;
      csr_wr_data  = 1'b0;
      third_bit_on = 1'b0;
      idle_on      = 1'b1;

      // Errors and the largest result are fixed; the rest come from the predictor.
      add_row(CHAN_INVALID,   8'd100, 8'h00, 8'h00, 8'h00, 1'b1, '0, STATUS_BAD_CHANNEL);
      add_row(CHAN_INVALID,   8'd0,   8'h00, 8'h00, 8'h00, 1'b1, '0, STATUS_BAD_CHANNEL);
      add_row(CHAN_INVALID,   8'd255, 8'hFF, 8'hFF, 8'hFF, 1'b1, '0, STATUS_BAD_CHANNEL);
      add_row(CHAN_FAN_ONE,   8'd0,   8'h00, 8'h00, 8'h00, 1'b1, '0, STATUS_STUCK);
      add_row(CHAN_FAN_TWO,   8'd255, 8'h00, 8'h00, 8'h00, 1'b1, '0, STATUS_STUCK);
      add_row(CHAN_FAN_THREE, 8'd0,   8'hFF, 8'hFF, 8'hFF, 1'b1, '0, STATUS_STUCK);
      add_row(CHAN_FAN_THREE, 8'd255, 8'hFF, 8'hFF, 8'hFF, 1'b1, '0, STATUS_STUCK);
      add_row(CHAN_FAN_ONE,   8'd1,   8'h00, 8'h00, 8'h00, 1'b1, 21'd1350000, STATUS_OK);
      add_row(CHAN_FAN_TWO,   8'd1,   8'h00, 8'h00, 8'h00, 1'b1, 21'd1350000, STATUS_OK);
      add_row(CHAN_FAN_THREE, 8'd1,   8'h00, 8'h00, 8'h00, 1'b1, 21'd1350000, STATUS_OK);
      add_row(CHAN_FAN_ONE,   8'd1,   8'hFF, 8'hFF, 8'hFF, 1'b0, '0, STATUS_OK);
      add_row(CHAN_FAN_THREE, 8'd254, 8'hFF, 8'hFF, 8'hFF, 1'b0, '0, STATUS_OK);
      add_row(CHAN_FAN_TWO,   8'd254, 8'h00, 8'h00, 8'h00, 1'b0, '0, STATUS_OK);
      add_row(CHAN_FAN_ONE,   8'd128, 8'h10, 8'h00, 8'h20, 1'b0, '0, STATUS_OK);
      add_row(CHAN_FAN_ONE,   8'd77,  8'h20, 8'hC0, 8'hC0, 1'b0, '0, STATUS_OK);
      add_row(CHAN_FAN_ONE,   8'd3,   8'h30, 8'h00, 8'h00, 1'b0, '0, STATUS_OK);
      add_row(CHAN_FAN_TWO,   8'd128, 8'h40, 8'h00, 8'h40, 1'b0, '0, STATUS_OK);
      add_row(CHAN_FAN_TWO,   8'd77,  8'h80, 8'hFF, 8'hA0, 1'b0, '0, STATUS_OK);
      add_row(CHAN_FAN_TWO,   8'd3,   8'hC0, 8'h00, 8'h00, 1'b0, '0, STATUS_OK);
      add_row(CHAN_FAN_THREE, 8'd128, 8'h00, 8'h40, 8'h80, 1'b0, '0, STATUS_OK);
      add_row(CHAN_FAN_THREE, 8'd77,  8'hFF, 8'h80, 8'h60, 1'b0, '0, STATUS_OK);
      add_row(CHAN_FAN_THREE, 8'd3,   8'h00, 8'hC0, 8'h00, 1'b0, '0, STATUS_OK);
      add_row(CHAN_FAN_ONE,   8'd85,  8'h5A, 8'hA5, 8'h55, 1'b0, '0, STATUS_OK);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_third_bit(1'b0);
      run_table();
      run_random(ITEMS_PER_PHASE, 0, 0);

      write_third_bit(1'b1);
      run_table();
      run_random(ITEMS_PER_PHASE, 100, 150);

      write_third_bit(1'b0);
      run_random(ITEMS_PER_PHASE, 0, 0);

      // Last stretch runs back to back on both sides after its first 100 items.
      write_third_bit(1'b1);
      run_random(ITEMS_PER_PHASE, 100, ITEMS_PER_PHASE);
      idle_on = 1'b0;

      @(negedge clock);
      req_valid = 1'b0;
      while (rpm_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### sim.f
rtl/fcr_pkg.sv
rtl/fcr_front.sv
rtl/fcr_queue.sv
rtl/fcr_back.sv
rtl/fan_count_to_rpm_core.sv
test/tb_fan_count_to_rpm_core.sv
